FILE: src/printf_spec_parser_defines.svh
// Assertion helpers for the parser top module
`ifndef PRINTF_SPEC_PARSER_DEFINES_SVH
`define PRINTF_SPEC_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PSP_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("parser check failed");

// Next-cycle implication, checked out of reset
`define PSP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("parser check failed");

`endif

FILE: src/psp_pkg.sv
package psp_pkg;

	// Characters of the specification grammar
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChMinus   = 8'h2D;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChHash    = 8'h23;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;
	localparam logic [7:0] ChStar    = 8'h2A;
	localparam logic [7:0] ChDot     = 8'h2E;
	localparam logic [7:0] ChLowH    = 8'h68;
	localparam logic [7:0] ChLowL    = 8'h6C;
	localparam logic [7:0] ChBigL    = 8'h4C;
	localparam logic [7:0] ChLowD    = 8'h64;
	localparam logic [7:0] ChLowI    = 8'h69;
	localparam logic [7:0] ChLowU    = 8'h75;
	localparam logic [7:0] ChLowB    = 8'h62;
	localparam logic [7:0] ChLowO    = 8'h6F;
	localparam logic [7:0] ChLowX    = 8'h78;
	localparam logic [7:0] ChBigX    = 8'h58;
	localparam logic [7:0] ChLowC    = 8'h63;
	localparam logic [7:0] ChLowS    = 8'h73;
	localparam logic [7:0] ChLowP    = 8'h70;
	localparam logic [7:0] ChLowN    = 8'h6E;

	// Conversion kinds
	localparam logic [3:0] ConvSigned  = 4'd0;
	localparam logic [3:0] ConvUnsigned = 4'd1;
	localparam logic [3:0] ConvBinary  = 4'd2;
	localparam logic [3:0] ConvOctal   = 4'd3;
	localparam logic [3:0] ConvHexLow  = 4'd4;
	localparam logic [3:0] ConvHexUp   = 4'd5;
	localparam logic [3:0] ConvChar    = 4'd6;
	localparam logic [3:0] ConvString  = 4'd7;
	localparam logic [3:0] ConvPointer = 4'd8;
	localparam logic [3:0] ConvCount   = 4'd9;
	localparam logic [3:0] ConvPercent = 4'd10;

	// Argument sizes
	localparam logic [2:0] SizeChar     = 3'd0;
	localparam logic [2:0] SizeShort    = 3'd1;
	localparam logic [2:0] SizeInt      = 3'd2;
	localparam logic [2:0] SizeLong     = 3'd3;
	localparam logic [2:0] SizeLongLong = 3'd4;

	// Sign modes
	localparam logic [1:0] SignDefault = 2'd0;
	localparam logic [1:0] SignPlus    = 2'd1;
	localparam logic [1:0] SignBlank   = 2'd2;

	// One parsed specification, or an error
	typedef struct packed {
		logic        status;
		logic        left_justify;
		logic [1:0]  sign_mode;
		logic        alt_prefix;
		logic        zero_pad;
		logic        width_from_arg;
		logic [15:0] field_width;
		logic        precision_from_arg;
		logic [15:0] precision;
		logic [2:0]  argument_size;
		logic [3:0]  conversion;
		logic [7:0]  spec_length;
	} psp_result_t;

endpackage

FILE: src/printf_spec_parser.sv
// printf conversion specification parser. Characters enter one per cycle while in_stall
// is low on the in_valid/in_stall channel; a conversion letter or a malformed character
// yields one result on out_valid/out_stall. An accepted character passes through the
// input register, then one pass of parse logic into the result register, which drives
// out_valid. A character that ends no specification always passes on, so the input
// stalls only when a terminating character finds the result register full and held by
// out_stall. Width and precision saturate at 2^NUMBER_BITS-1 and are reported in their
// low 16 bits.
module printf_spec_parser #(
	parameter int NUMBER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        left_justify,
	output logic [1:0]  sign_mode,
	output logic        alt_prefix,
	output logic        zero_pad,
	output logic        width_from_arg,
	output logic [15:0] field_width,
	output logic        precision_from_arg,
	output logic [15:0] precision,
	output logic [2:0]  argument_size,
	output logic [3:0]  conversion,
	output logic [7:0]  spec_length
);

	import psp_pkg::*;

	`include "printf_spec_parser_defines.svh"

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        adv;
	logic        emit;
	psp_result_t result;
	psp_result_t res_q;
	logic        out_valid_q;
	logic        out_free;

	// Take the character in s1 unless its result has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !adv;

	psp_parse #(.NUMBER_BITS(NUMBER_BITS)) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.ch    (char_s1),
		.emit  (emit),
		.result(result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
		end
	end

	// Result register: load a new item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= result;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = res_q.status;
	assign left_justify       = res_q.left_justify;
	assign sign_mode          = res_q.sign_mode;
	assign alt_prefix         = res_q.alt_prefix;
	assign zero_pad           = res_q.zero_pad;
	assign width_from_arg     = res_q.width_from_arg;
	assign field_width        = res_q.field_width;
	assign precision_from_arg = res_q.precision_from_arg;
	assign precision          = res_q.precision;
	assign argument_size      = res_q.argument_size;
	assign conversion         = res_q.conversion;
	assign spec_length        = res_q.spec_length;

	// A waiting result is never overwritten
	`PSP_ASSERT_NOW(a_no_overwrite, adv && emit, !(out_valid_q && out_stall))
	// An error item carries nothing but its status
	`PSP_ASSERT_NOW(a_error_clean, out_valid_q && res_q.status,
		(res_q.spec_length == 8'd0) && (res_q.field_width == 16'd0) &&
		(res_q.conversion == ConvSigned))
	// A good specification spans at least the percent and the letter
	`PSP_ASSERT_NOW(a_spec_len, out_valid_q && !res_q.status, res_q.spec_length >= 8'd2)
	// A stalled input means the parse is blocked by a held result
	`PSP_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && emit && out_valid_q && out_stall)

endmodule

FILE: src/psp_dec_acc.sv
module psp_dec_acc #(
	parameter int NUMBER_BITS = 16,
	parameter int AccW = (NUMBER_BITS > 16) ? NUMBER_BITS : 16
) (
	input  logic [AccW-1:0] acc_in,
	input  logic [3:0]      digit,
	output logic [AccW-1:0] acc_out
);

	localparam int SumW = AccW + 4;
	localparam logic [SumW-1:0] MaxVal = SumW'((64'd1 << NUMBER_BITS) - 64'd1);

	logic [SumW-1:0] sum;

	// Multiply by ten as two shifts, add the digit, clamp at the top value
	assign sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {{AccW{1'b0}}, digit};
	assign acc_out = (sum > MaxVal) ? MaxVal[AccW-1:0] : sum[AccW-1:0];

endmodule

FILE: src/psp_parse.sv
module psp_parse #(
	parameter int NUMBER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          ch,
	output logic                emit,
	output psp_pkg::psp_result_t result
);

	import psp_pkg::*;

	localparam int AccW = (NUMBER_BITS > 16) ? NUMBER_BITS : 16;

	typedef enum logic [2:0] {
		PH_IDLE, PH_FLAGS, PH_WDIG, PH_WDONE, PH_PSTART, PH_PDIG, PH_LEN, PH_LDONE
	} phase_t;

	phase_t          phase_q, phase_d;
	logic            lj_q, lj_d;
	logic [1:0]      sign_q, sign_d;
	logic            alt_q, alt_d;
	logic            zp_q, zp_d;
	logic            wstar_q, wstar_d;
	logic            pstar_q, pstar_d;
	logic [AccW-1:0] width_q, width_d;
	logic [AccW-1:0] prec_q, prec_d;
	logic [2:0]      lc_q, lc_d;
	logic [7:0]      cnt_q, cnt_d;

	logic            is_digit;
	logic [AccW-1:0] wacc_in, wacc_out, pacc_in, pacc_out;
	logic            conv_hit, conv_sized;
	logic [3:0]      conv_code;
	logic            at_flags_flag, at_wdone, at_len;
	logic [7:0]      cnt_inc;

	assign is_digit = (ch >= ChZero) && (ch <= ChNine);

	// Digit accumulators start from zero on the first digit
	assign wacc_in = (phase_q == PH_WDIG) ? width_q : '0;
	assign pacc_in = (phase_q == PH_PDIG) ? prec_q : '0;

	psp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_wacc (
		.acc_in (wacc_in),
		.digit  (ch[3:0]),
		.acc_out(wacc_out)
	);

	psp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_pacc (
		.acc_in (pacc_in),
		.digit  (ch[3:0]),
		.acc_out(pacc_out)
	);

	// Decode the conversion letter
	always_comb begin
		conv_hit   = 1'b1;
		conv_sized = 1'b0;
		conv_code  = ConvSigned;
		unique case (ch)
			ChLowD, ChLowI: begin conv_code = ConvSigned;   conv_sized = 1'b1; end
			ChLowU:         begin conv_code = ConvUnsigned; conv_sized = 1'b1; end
			ChLowB:         begin conv_code = ConvBinary;   conv_sized = 1'b1; end
			ChLowO:         begin conv_code = ConvOctal;    conv_sized = 1'b1; end
			ChLowX:         begin conv_code = ConvHexLow;   conv_sized = 1'b1; end
			ChBigX:         begin conv_code = ConvHexUp;    conv_sized = 1'b1; end
			ChLowC:         conv_code = ConvChar;
			ChLowS:         conv_code = ConvString;
			ChLowP:         conv_code = ConvPointer;
			ChLowN:         conv_code = ConvCount;
			ChPercent:      conv_code = ConvPercent;
			default:        conv_hit = 1'b0;
		endcase
	end

	assign at_flags_flag = (phase_q == PH_FLAGS) && ((ch == ChMinus) || (ch == ChPlus) ||
		(ch == ChSpace) || (ch == ChHash) || (ch == ChZero) || (ch == ChStar));
	assign at_wdone = (phase_q == PH_FLAGS) || (phase_q == PH_WDIG) || (phase_q == PH_WDONE);
	assign at_len   = (phase_q != PH_IDLE) && (phase_q != PH_LDONE);
	assign cnt_inc  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

	// Advance the parse by one character
	always_comb begin
		phase_d = phase_q;
		lj_d    = lj_q;
		sign_d  = sign_q;
		alt_d   = alt_q;
		zp_d    = zp_q;
		wstar_d = wstar_q;
		pstar_d = pstar_q;
		width_d = width_q;
		prec_d  = prec_q;
		lc_d    = lc_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		result  = '0;
		if (phase_q == PH_IDLE) begin
			if (ch == ChPercent) begin
				lj_d    = 1'b0;
				sign_d  = SignDefault;
				alt_d   = 1'b0;
				zp_d    = 1'b0;
				wstar_d = 1'b0;
				pstar_d = 1'b0;
				width_d = '0;
				prec_d  = '0;
				lc_d    = SizeInt;
				cnt_d   = 8'd1;
				phase_d = PH_FLAGS;
			end else begin
				emit          = 1'b1;
				result.status = 1'b1;
			end
		end else begin
			cnt_d = cnt_inc;
			if (at_flags_flag) begin
				case (ch)
					ChMinus: lj_d = 1'b1;
					ChPlus:  sign_d = SignPlus;
					ChSpace: sign_d = SignBlank;
					ChHash:  alt_d = 1'b1;
					ChZero:  zp_d = 1'b1;
					default: begin wstar_d = 1'b1; phase_d = PH_WDONE; end
				endcase
			end else if (((phase_q == PH_FLAGS) || (phase_q == PH_WDIG)) && is_digit) begin
				width_d = wacc_out;
				phase_d = PH_WDIG;
			end else if (at_wdone && (ch == ChDot)) begin
				phase_d = PH_PSTART;
			end else if ((phase_q == PH_PSTART) && (ch == ChStar)) begin
				pstar_d = 1'b1;
				phase_d = PH_LEN;
			end else if (((phase_q == PH_PSTART) || (phase_q == PH_PDIG)) && is_digit) begin
				prec_d  = pacc_out;
				phase_d = PH_PDIG;
			end else if (at_len && (ch == ChLowH) && (lc_q != SizeChar)) begin
				lc_d    = lc_q - 3'd1;
				phase_d = (lc_q == SizeShort) ? PH_LDONE : PH_LEN;
			end else if (at_len && (ch == ChLowL) && (lc_q < SizeLongLong)) begin
				lc_d    = lc_q + 3'd1;
				phase_d = (lc_q == SizeLong) ? PH_LDONE : PH_LEN;
			end else if (at_len && (ch == ChBigL) && (lc_q < SizeLongLong)) begin
				lc_d    = lc_q + 3'd1;
				phase_d = PH_LDONE;
			end else begin
				// Conversion letter or a bad character ends the specification
				emit    = 1'b1;
				phase_d = PH_IDLE;
				if (conv_hit) begin
					result.left_justify       = lj_q;
					result.sign_mode          = sign_q;
					result.alt_prefix         = alt_q;
					result.zero_pad           = zp_q;
					result.width_from_arg     = wstar_q;
					result.field_width        = width_q[15:0];
					result.precision_from_arg = pstar_q;
					result.precision          = prec_q[15:0];
					result.argument_size      = conv_sized ? lc_q : SizeChar;
					result.conversion         = conv_code;
					result.spec_length        = cnt_inc;
				end else begin
					result.status = 1'b1;
				end
			end
		end
	end

	// Hold parse state; update only when the character in s1 advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lj_q    <= 1'b0;
			sign_q  <= SignDefault;
			alt_q   <= 1'b0;
			zp_q    <= 1'b0;
			wstar_q <= 1'b0;
			pstar_q <= 1'b0;
			width_q <= '0;
			prec_q  <= '0;
			lc_q    <= SizeChar;
			cnt_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			lj_q    <= lj_d;
			sign_q  <= sign_d;
			alt_q   <= alt_d;
			zp_q    <= zp_d;
			wstar_q <= wstar_d;
			pstar_q <= pstar_d;
			width_q <= width_d;
			prec_q  <= prec_d;
			lc_q    <= lc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
